>>> sv/lrpr_pkg.sv
package lrpr_pkg;

  // stream characters
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;

  // input commands
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // user facility with notice level
  localparam logic [9:0] DEFAULT_PRI = 10'd13;
  localparam int unsigned FAC_FIELD_W = 7;
  localparam logic [FAC_FIELD_W-1:0] USER_FAC = 7'd1;

  localparam logic [7:0] ALL_LEVELS = 8'hFF;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_START,
    PH_DIGITS,
    PH_VALID,
    PH_NONE
  } lrpr_phase_e;

  typedef enum logic {
    ENT_WRITE,
    ENT_RECORD
  } lrpr_kind_e;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic [3:0] rule_index;
    logic [4:0] facility_index;
    logic [7:0] level_mask;
  } lrpr_in_t;

  typedef struct packed {
    logic [11:0] rule_hits;
    logic [4:0]  facility;
    logic [2:0]  level;
    logic [8:0]  body_start;
    logic [8:0]  body_length;
    logic        prefix_valid;
    logic        truncated;
  } lrpr_out_t;

  // one queue entry: either a table write or a finished line
  typedef struct packed {
    lrpr_kind_e             kind;
    logic [3:0]             rule_index;
    logic [FAC_FIELD_W-1:0] facility;
    logic [2:0]             level;
    logic [7:0]             wmask;
    logic [8:0]             body_start;
    logic [8:0]             body_length;
    logic                   prefix_valid;
    logic                   truncated;
  } lrpr_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lrpr_qstat_t;

  // reset content of the rule table
  function automatic logic [7:0] init_mask(input logic first_rule,
                                           input logic [FAC_FIELD_W-1:0] fac);
    logic named;
    named = (fac < 7'd10) || ((fac >= 7'd16) && (fac < 7'd24));
    return (first_rule && named) ? ALL_LEVELS : 8'h00;
  endfunction

endpackage

>>> sv/log_record_priority_router_core.sv
// log record priority router
// input channel (in_valid_i / in_stall_o / in_data_i): one transaction per cycle
//   unless stalled: a stream byte (command 0) or one rule table write (command 1)
// output channel (out_valid_o / out_stall_i / out_data_o): one transaction per
//   non-empty line, queued when its newline byte is taken
// config: cfg_we_i writes cfg_wdata_i into rule_count; the user must do so only
// while the block is idle, which the block does not enforce; the front parses each
// byte in the cycle it is taken and pushes line records and table writes into a
// four-entry queue; the back pops one entry per cycle when not stalled, writes the
// rule table or reads one table row per rule, and builds the hit mask
// a result passes through the queue pop with table read, then the output register
// throughput: one transaction per cycle per channel when not stalled; the single
//   pop per cycle from the queue, paired with one table read, sets that rate
// reset: line state clears at once, then a clearing pass writes the reset table
//   content row by row, one row per facility, with in_stall_o held high
// a stalled receiver keeps the result in the output register; the back stage and
//   the queue fill behind it, and in_stall_o rises once the queue is full
module log_record_priority_router_core
  import lrpr_pkg::*;
#(
  parameter int unsigned RULES      = 12,
  parameter int unsigned FACILITIES = 24,
  parameter int unsigned LINE_BYTES = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  lrpr_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output lrpr_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i
);

  logic [3:0]  rule_count_q, rule_count_d;
  logic        accept;
  logic        push;
  logic        pop;
  logic        busy;
  lrpr_entry_t entry;
  lrpr_entry_t head;
  lrpr_qstat_t qstat;

  // rule count register, reset to one rule in use
  assign rule_count_d = cfg_we_i ? cfg_wdata_i : rule_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= 4'd1;
    end else begin
      rule_count_q <= rule_count_d;
    end
  end

  // hold off input while the queue is full or the table is being cleared
  assign in_stall_o = qstat.full || busy;
  assign accept     = in_valid_i && !in_stall_o;

  // front: byte parser and line bookkeeping
  lrpr_front #(
    .RULES     (RULES),
    .FACILITIES(FACILITIES),
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_data_i(in_data_i),
    .push_o   (push),
    .entry_o  (entry)
  );

  // decoupling queue between parser and table lookup
  lrpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .status_o(qstat)
  );

  // back: rule table, lookup and output register
  lrpr_back #(
    .RULES     (RULES),
    .FACILITIES(FACILITIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .rule_count_i(rule_count_q),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // queue never overflows
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && qstat.full))
    else $error("push into full queue");

  // queue never underflows
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // nothing moves through the queue during the clearing pass
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (!push && !pop))
    else $error("queue traffic during table clear");

  // a delivered record always carries a facility in range
  a_fac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.facility) < 32'(FACILITIES)))
    else $error("facility out of range");

endmodule

>>> sv/lrpr_ram.sv
module lrpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/lrpr_front.sv
module lrpr_front
  import lrpr_pkg::*;
#(
  parameter int unsigned RULES      = 12,
  parameter int unsigned FACILITIES = 24,
  parameter int unsigned LINE_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  lrpr_in_t    in_data_i,
  output logic        push_o,
  output lrpr_entry_t entry_o
);

  localparam int unsigned CntW = $clog2(LINE_BYTES);
  localparam logic [CntW-1:0] KeepLast = CntW'(LINE_BYTES - 1);

  lrpr_phase_e     phase_q, phase_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic [CntW-1:0] text_q, text_d;
  logic [CntW-1:0] plen_q, plen_d;
  logic [9:0]      acc_q, acc_d;
  logic            zero_q, zero_d;
  logic            ovf_q, ovf_d;

  // end of line values
  logic                   pfx_ok;
  logic [9:0]             pri;
  logic [FAC_FIELD_W-1:0] fac_raw;
  logic [FAC_FIELD_W-1:0] fac_fix;
  logic [CntW-1:0]        start;
  logic [CntW-1:0]        len;
  logic                   non_empty;
  logic [7:0]             b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      kept_q  <= '0;
      text_q  <= '0;
      plen_q  <= '0;
      acc_q   <= '0;
      zero_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      kept_q  <= kept_d;
      text_q  <= text_d;
      plen_q  <= plen_d;
      acc_q   <= acc_d;
      zero_q  <= zero_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    b         = in_data_i.data_byte;
    pfx_ok    = (phase_q == PH_VALID);
    pri       = pfx_ok ? acc_q : DEFAULT_PRI;
    fac_raw   = pri[9:3];
    fac_fix   = (32'(fac_raw) >= 32'(FACILITIES)) ? USER_FAC : fac_raw;
    start     = pfx_ok ? plen_q : '0;
    non_empty = (kept_q != '0) && (text_q > start);
    len       = text_q - start;

    phase_d = phase_q;
    kept_d  = kept_q;
    text_d  = text_q;
    plen_d  = plen_q;
    acc_d   = acc_q;
    zero_d  = zero_q;
    ovf_d   = ovf_q;
    push_o  = 1'b0;
    entry_o = '0;

    if (accept_i) begin
      if (in_data_i.command == CMD_WRITE) begin
        // out-of-range entries are dropped here
        if ((32'(in_data_i.rule_index) < 32'(RULES)) &&
            (32'(in_data_i.facility_index) < 32'(FACILITIES))) begin
          push_o             = 1'b1;
          entry_o.kind       = ENT_WRITE;
          entry_o.rule_index = in_data_i.rule_index;
          entry_o.facility   = FAC_FIELD_W'(in_data_i.facility_index);
          entry_o.wmask      = in_data_i.level_mask;
        end
      end else if (b == CH_NL) begin
        if (non_empty) begin
          push_o               = 1'b1;
          entry_o.kind         = ENT_RECORD;
          entry_o.facility     = fac_fix;
          entry_o.level        = pri[2:0];
          entry_o.body_start   = 9'(start);
          entry_o.body_length  = 9'(len);
          entry_o.prefix_valid = pfx_ok;
          entry_o.truncated    = ovf_q;
        end
        phase_d = PH_START;
        kept_d  = '0;
        text_d  = '0;
        plen_d  = '0;
        acc_d   = '0;
        zero_d  = 1'b0;
        ovf_d   = 1'b0;
      end else if (kept_q < KeepLast) begin
        kept_d = CntW'(kept_q + 1'b1);
        if (!zero_q) begin
          if (b == CH_NUL) begin
            zero_d = 1'b1;
            if (phase_q == PH_DIGITS) begin
              phase_d = PH_NONE;
            end
          end else begin
            text_d = CntW'(text_q + 1'b1);
            case (phase_q)
              PH_START: begin
                if (b == CH_LT) begin
                  phase_d = PH_DIGITS;
                  acc_d   = '0;
                end else begin
                  phase_d = PH_NONE;
                end
              end
              PH_DIGITS: begin
                if ((b >= CH_D0) && (b <= CH_D9)) begin
                  acc_d = 10'((acc_q << 3) + (acc_q << 1) + {6'd0, b[3:0]});
                end else if (b == CH_GT) begin
                  phase_d = PH_VALID;
                  plen_d  = CntW'(kept_q + 1'b1);
                end else begin
                  phase_d = PH_NONE;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

endmodule

>>> sv/lrpr_queue.sv
module lrpr_queue
  import lrpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  lrpr_entry_t entry_i,
  input  logic        pop_i,
  output lrpr_entry_t head_o,
  output lrpr_qstat_t status_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  lrpr_entry_t     slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? PtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? PtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  assign head_o         = slot_q[rd_q];
  assign status_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

>>> sv/lrpr_back.sv
module lrpr_back
  import lrpr_pkg::*;
#(
  parameter int unsigned RULES      = 12,
  parameter int unsigned FACILITIES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lrpr_entry_t head_i,
  input  lrpr_qstat_t qstat_i,
  input  logic [3:0]  rule_count_i,
  output logic        pop_o,
  output logic        busy_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lrpr_out_t   out_data_o
);

  localparam int unsigned AddrW = $clog2(FACILITIES);

  logic             clr_q, clr_d;
  logic [AddrW-1:0] clr_addr_q, clr_addr_d;
  logic             s1_valid_q, s1_valid_d;
  lrpr_entry_t      s1_q, s1_d;
  logic             out_valid_q, out_valid_d;
  lrpr_out_t        out_q, out_d;

  logic             advance;
  logic             pop_rec;
  logic             pop_wr;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata [RULES];
  logic [RULES-1:0] hits;

  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = !qstat_i.empty && !clr_q && (!s1_valid_q || advance);
  assign pop_rec = pop_o && (head_i.kind == ENT_RECORD);
  assign pop_wr  = pop_o && (head_i.kind == ENT_WRITE);
  assign waddr   = clr_q ? clr_addr_q : head_i.facility[AddrW-1:0];
  assign raddr   = head_i.facility[AddrW-1:0];

  for (genvar r = 0; r < RULES; r++) begin : g_rule
    logic       we;
    logic [7:0] wdata;

    assign we    = clr_q || (pop_wr && (32'(head_i.rule_index) == 32'(r)));
    assign wdata = clr_q ? init_mask(r == 0, FAC_FIELD_W'(clr_addr_q)) : head_i.wmask;

    lrpr_ram #(
      .WIDTH(8),
      .DEPTH(FACILITIES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .re_i   (pop_rec),
      .raddr_i(raddr),
      .rdata_o(rdata[r])
    );

    assign hits[r] = (32'(r) < 32'(rule_count_i)) && rdata[r][s1_q.level];
  end

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = AddrW'(clr_addr_q + 1'b1);
      if (clr_addr_q == AddrW'(FACILITIES - 1)) begin
        clr_d = 1'b0;
      end
    end

    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (pop_o) begin
      s1_valid_d = pop_rec;
      s1_d       = head_i;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d        = s1_valid_q;
      out_d.rule_hits    = 12'(hits);
      out_d.facility     = 5'(s1_q.facility);
      out_d.level        = s1_q.level;
      out_d.body_start   = s1_q.body_start;
      out_d.body_length  = s1_q.body_length;
      out_d.prefix_valid = s1_q.prefix_valid;
      out_d.truncated    = s1_q.truncated;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_q       <= clr_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign busy_o      = clr_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// log record priority router: line parse, priority decode and rule match
// stimulus is a short directed list, then four random phases that change the
// rule count and the idling pattern on both channels
module testbench;
  import lrpr_pkg::*;

  localparam int unsigned NUM_RULES     = 12;
  localparam int unsigned NUM_FACS      = 24;
  localparam int unsigned KEEP_MAX      = 511;  // bytes of a line that are kept
  localparam int unsigned SETTLE_CYCLES = 8;    // covers the path through the queue and the back stage
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PHASE_ITEMS   = 40;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  // predicts one record per non-empty line and checks records in order
  class record_scoreboard;
    logic [7:0]  level_masks [NUM_RULES][NUM_FACS];
    logic [3:0]  rules_in_use;
    logic [8:0]  kept_bytes;
    logic [8:0]  text_bytes;
    logic [8:0]  prefix_bytes;
    logic [9:0]  pri_accum;
    lrpr_phase_e phase;
    logic        zero_hit;
    logic        dropped;
    lrpr_out_t   expected_records[$];
    int unsigned mismatches;

    function new();
      for (int r = 0; r < NUM_RULES; r++) begin
        for (int f = 0; f < NUM_FACS; f++) begin
          level_masks[r][f] = (r == 0 && (f < 10 || f >= 16)) ? 8'hFF : 8'h00;
        end
      end
      rules_in_use = 4'd1;
      mismatches   = 0;
      clear_line();
    endfunction

    function void clear_line();
      kept_bytes   = '0;
      text_bytes   = '0;
      prefix_bytes = '0;
      pri_accum    = '0;
      phase        = PH_START;
      zero_hit     = 1'b0;
      dropped      = 1'b0;
    endfunction

    function void set_rule_count(logic [3:0] value);
      rules_in_use = value;
    endfunction

    function int unsigned pending();
      return expected_records.size();
    endfunction

    function void close_line();
      logic        valid;
      logic [9:0]  pri;
      logic [6:0]  fac;
      logic [8:0]  start;
      int unsigned n;
      lrpr_out_t   rec;
      valid = (phase == PH_VALID);
      pri   = valid ? pri_accum : DEFAULT_PRI;
      fac   = pri[9:3];
      start = valid ? prefix_bytes : 9'd0;
      if (kept_bytes == 0 || text_bytes <= start) return;
      if (fac >= NUM_FACS) fac = USER_FAC;
      n   = (rules_in_use > NUM_RULES) ? NUM_RULES : rules_in_use;
      rec = '0;
      for (int r = 0; r < n; r++) begin
        if (level_masks[r][fac][pri[2:0]]) rec.rule_hits[r] = 1'b1;
      end
      rec.facility     = fac[4:0];
      rec.level        = pri[2:0];
      rec.body_start   = start;
      rec.body_length  = text_bytes - start;
      rec.prefix_valid = valid;
      rec.truncated    = dropped;
      expected_records.push_back(rec);
    endfunction

    function void note_item(lrpr_in_t it);
      logic [8:0] pos;
      if (it.command == CMD_WRITE) begin
        if (it.rule_index < NUM_RULES && it.facility_index < NUM_FACS)
          level_masks[it.rule_index][it.facility_index] = it.level_mask;
        return;
      end
      if (it.data_byte == CH_NL) begin
        close_line();
        clear_line();
        return;
      end
      if (kept_bytes >= KEEP_MAX) begin
        dropped = 1'b1;
        return;
      end
      pos        = kept_bytes;
      kept_bytes = kept_bytes + 9'd1;
      if (zero_hit) return;
      if (it.data_byte == CH_NUL) begin
        zero_hit = 1'b1;
        if (phase == PH_DIGITS) phase = PH_NONE;
        return;
      end
      text_bytes = text_bytes + 9'd1;
      case (phase)
        PH_START: begin
          phase = (it.data_byte == CH_LT) ? PH_DIGITS : PH_NONE;
        end
        PH_DIGITS: begin
          if (it.data_byte >= CH_D0 && it.data_byte <= CH_D9) begin
            pri_accum = 10'(pri_accum * 10 + (it.data_byte - CH_D0));
          end else if (it.data_byte == CH_GT) begin
            phase        = PH_VALID;
            prefix_bytes = pos + 9'd1;
          end else begin
            phase = PH_NONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void report_mismatch(string what, lrpr_out_t want, lrpr_out_t got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t %s: expected hits=%03h fac=%0d lev=%0d start=%0d len=%0d pv=%0b tr=%0b",
                 $realtime, what, want.rule_hits, want.facility, want.level,
                 want.body_start, want.body_length, want.prefix_valid, want.truncated);
      if (mismatches <= REPORT_LIMIT)
        $display("%0t %s: actual   hits=%03h fac=%0d lev=%0d start=%0d len=%0d pv=%0b tr=%0b",
                 $realtime, what, got.rule_hits, got.facility, got.level,
                 got.body_start, got.body_length, got.prefix_valid, got.truncated);
    endfunction

    function void check_record(lrpr_out_t got);
      lrpr_out_t want;
      logic      bad;
      if (expected_records.size() == 0) begin
        report_mismatch("record with none expected", '0, got);
        return;
      end
      want = expected_records.pop_front();
      bad  = (got.rule_hits !== want.rule_hits) || (got.facility !== want.facility) ||
             (got.level !== want.level) || (got.body_start !== want.body_start) ||
             (got.body_length !== want.body_length) ||
             (got.prefix_valid !== want.prefix_valid) || (got.truncated !== want.truncated);
      if (bad) report_mismatch("record mismatch", want, got);
    endfunction
  endclass

  // every block input starts at a known value
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  lrpr_in_t   in_data_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  lrpr_out_t  out_data_o;

  record_scoreboard records;

  // idling knobs, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off: requested by the stimulus, counted down by the receiver
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;

  log_record_priority_router_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // both handshakes sampled at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) records.note_item(in_data_i);
      if (out_valid_o && !out_stall_i) records.check_record(out_data_o);
    end
  end

  // receiver: random stalls, or a solid hold-off while a hold request runs
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // sender: optional idle cycles, then hold the transaction until it is taken
  task automatic send_item(lrpr_in_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  // unused fields of a transaction still carry random bits
  function automatic lrpr_in_t byte_item(logic [7:0] b);
    lrpr_in_t it;
    it.command        = CMD_BYTE;
    it.data_byte      = b;
    it.rule_index     = 4'($urandom_range(15));
    it.facility_index = 5'($urandom_range(31));
    it.level_mask     = 8'($urandom_range(255));
    return it;
  endfunction

  task automatic send_byte(logic [7:0] b);
    send_item(byte_item(b));
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_write(logic [3:0] ri, logic [4:0] fi, logic [7:0] m);
    lrpr_in_t it;
    it.command        = CMD_WRITE;
    it.data_byte      = 8'($urandom_range(255));
    it.rule_index     = ri;
    it.facility_index = fi;
    it.level_mask     = m;
    send_item(it);
  endtask

  // mostly in-range entries, some outside the table that must be ignored
  task automatic random_write();
    if ($urandom_range(99) < 80)
      send_write(4'($urandom_range(NUM_RULES - 1)), 5'($urandom_range(NUM_FACS - 1)),
                 8'($urandom_range(255)));
    else
      send_write(4'($urandom_range(15)), 5'($urandom_range(31)), 8'($urandom_range(255)));
  endtask

  // no transaction in flight: all records back, and time for trailing writes
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (records.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rule_count(logic [3:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    records.set_rule_count(value);
  endtask

  // priority digits: small values that hit the table, long strings that wrap
  task automatic send_digits();
    int unsigned pick;
    string       s;
    pick = $urandom_range(99);
    s    = "";
    if (pick < 70) begin
      s = $sformatf("%0d", $urandom_range(0, 191));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 6)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    send_text(s);
  endtask

  function automatic logic [7:0] body_byte();
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 80) return 8'($urandom_range(32, 126));
    if (pick < 88) return CH_NUL;
    b = 8'($urandom_range(1, 255));
    return (b == CH_NL) ? 8'd11 : b;
  endfunction

  // one line: well-formed prefix most of the time, broken or missing otherwise
  task automatic send_random_line();
    int unsigned kind;
    int unsigned nbody;
    int unsigned term;
    logic [7:0]  b;
    kind  = $urandom_range(99);
    nbody = $urandom_range(0, 10);
    if (kind < 8) begin
      // noise: anything, newlines and writes included
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(3) == 0) random_write();
        else send_byte(8'($urandom_range(255)));
      end
      return;
    end
    if (kind < 65) begin
      send_byte(CH_LT);
      send_digits();
      send_byte(CH_GT);
    end else if (kind < 82) begin
      // unterminated prefix: zero byte, stray byte or the line end
      send_byte(CH_LT);
      send_digits();
      term = $urandom_range(2);
      if (term == 0) send_byte(CH_NUL);
      else if (term == 1) send_byte(8'($urandom_range(8'h61, 8'h7A)));
      else nbody = 0;
    end else begin
      b = body_byte();
      send_byte((b == CH_LT) ? 8'h41 : b);
    end
    repeat (nbody) begin
      if ($urandom_range(99) < 12) random_write();
      send_byte(body_byte());
    end
    send_byte(CH_NL);
  endtask

  // widest prefix: 508 digits, body of one byte at offset 510, tail dropped
  task automatic send_long_prefix_line();
    send_byte(CH_LT);
    repeat (508) send_byte(8'(CH_D0 + $urandom_range(9)));
    send_byte(CH_GT);
    send_byte(8'h78);
    repeat (6) send_byte(8'h79);
    send_byte(CH_NL);
  endtask

  // longest body: exactly the kept length, nothing dropped
  task automatic send_full_plain_line();
    logic [7:0] b;
    send_byte(8'h41);
    repeat (KEEP_MAX - 1) begin
      b = 8'($urandom_range(1, 255));
      send_byte((b == CH_NL) ? 8'd11 : b);
    end
    send_byte(CH_NL);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_line();
  endtask

  initial begin
    int unsigned guard;
    records = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset rule count, reset table
    send_byte(CH_NL);                             // empty line
    send_text("<>");                              // prefix only, empty body
    send_byte(CH_NL);
    send_text("<>");                              // empty digits, write mid-line
    send_write(4'd0, 5'd0, 8'h01);
    send_text("a");
    send_byte(CH_NL);
    send_text("<12");                             // prefix cut by a zero byte
    send_byte(CH_NUL);
    send_byte(CH_NL);
    send_text("<9x");                             // prefix cut by a stray byte
    send_byte(CH_NL);
    send_text("<5");                              // prefix cut by the line end
    send_byte(CH_NL);
    send_text("<1025>b");                         // priority wraps at 1024
    send_byte(CH_NL);
    send_write(4'd12, 5'd0, 8'hFF);               // rule outside the table
    send_write(4'd0, 5'd24, 8'hFF);               // facility outside the table

    // all rules, no idling; long hold-off fills the block and stalls the input
    write_rule_count(4'd12);
    repeat (20) send_write(4'($urandom_range(NUM_RULES - 1)),
                           5'($urandom_range(NUM_FACS - 1)), 8'($urandom_range(255)));
    hold_req = 80;
    repeat (12) begin
      send_byte(CH_LT);
      send_digits();
      send_byte(CH_GT);
      send_byte(body_byte());
      send_byte(CH_NL);
    end
    wait_drain();
    run_random(PHASE_ITEMS);

    // rule count above the table, sender idles
    write_rule_count(4'd15);
    send_idle_pct = 51;
    send_long_prefix_line();
    run_random(PHASE_ITEMS);

    // no rules in use, receiver stalls
    write_rule_count(4'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    send_full_plain_line();
    run_random(PHASE_ITEMS);

    // some rules, light idling on both sides
    write_rule_count(4'($urandom_range(1, NUM_RULES - 1)));
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    run_random(PHASE_ITEMS);

    // all sent: let the last records come back
    in_valid_i <= 1'b0;
    guard = 0;
    while (records.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (records.pending() != 0) begin
      $display("%0d expected records never arrived", records.pending());
      records.mismatches += records.pending();
    end
    if (records.mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
